/* rtl/periodic_task_timer_table_macros.svh */
`ifndef PERIODIC_TASK_TIMER_TABLE_MACROS_SVH
`define PERIODIC_TASK_TIMER_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PTT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PTT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/ptt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ptt_pkg;

	localparam int SLOTS = 20;
	// slot position / one-based id, wide enough to hold SLOTS
	localparam int ID_W  = $clog2(SLOTS + 1);
	localparam int SID_W = 5;
	localparam int RID_W = 5;
	localparam int PER_W = 16;
	localparam int CMP_W = (ID_W > SID_W) ? ID_W : SID_W;

	typedef enum logic [1:0] {
		K_TICK   = 2'd0,
		K_ADD    = 2'd1,
		K_REMOVE = 2'd2,
		K_FINISH = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		RK_FIRE     = 3'd0,
		RK_ADD      = 3'd1,
		RK_REMOVE   = 3'd2,
		RK_TICKDONE = 3'd3,
		RK_FINISH   = 3'd4
	} rkind_t;

	// request token walking the cell row
	typedef struct packed {
		logic             valid;
		kind_t            kind;
		logic [SID_W-1:0] slot_id;
		logic [PER_W-1:0] period;
		logic             keep;
		logic [ID_W-1:0]  pos;  // index of the cell the token enters next
		logic [ID_W-1:0]  got;  // id claimed, freed or finished so far, 0 if none
	} tok_t;

	typedef struct packed {
		logic            valid;
		logic [ID_W-1:0] id;
	} fire_t;

endpackage

`default_nettype wire

/* rtl/ptt_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module ptt_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          adv,
	input  wire ptt_pkg::tok_t tok_in,
	output ptt_pkg::tok_t      tok_out,
	output ptt_pkg::fire_t     fire
);

	logic [ptt_pkg::PER_W-1:0] period_q, period_d;
	logic [ptt_pkg::PER_W-1:0] rem_q, rem_d;
	logic                      pend_q, pend_d;
	ptt_pkg::tok_t             tok_q, nxt;
	logic [ptt_pkg::ID_W-1:0]  my_id;
	logic                      act, busy, hit;

	assign act   = tok_in.valid && adv;
	assign busy  = (period_q != '0);
	assign my_id = tok_in.pos + ptt_pkg::ID_W'(1);
	assign hit   = (ptt_pkg::CMP_W'(tok_in.slot_id) == ptt_pkg::CMP_W'(my_id));

	always_comb begin
		nxt        = tok_in;
		nxt.pos    = my_id;
		period_d   = period_q;
		rem_d      = rem_q;
		pend_d     = pend_q;
		fire.valid = 1'b0;
		fire.id    = my_id;
		case (tok_in.kind)
			ptt_pkg::K_TICK: begin
				if (busy && !pend_q) begin
					if (rem_q != '0) begin
						rem_d = rem_q - ptt_pkg::PER_W'(1);
					end else begin
						pend_d     = 1'b1;
						fire.valid = act;
					end
				end
			end
			ptt_pkg::K_ADD: begin
				// first free cell on the way claims the request
				if (!busy && tok_in.got == '0) begin
					period_d = tok_in.period;
					rem_d    = tok_in.period;
					pend_d   = 1'b0;
					nxt.got  = my_id;
				end
			end
			ptt_pkg::K_REMOVE: begin
				if (hit && busy) begin
					period_d = '0;
					pend_d   = 1'b0;
					nxt.got  = my_id;
				end
			end
			ptt_pkg::K_FINISH: begin
				if (hit && busy && pend_q) begin
					pend_d = 1'b0;
					if (tok_in.keep) begin
						rem_d = period_q;
					end else begin
						period_d = '0;
					end
					nxt.got = my_id;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= '0;
			pend_q   <= 1'b0;
		end else if (act) begin
			period_q <= period_d;
			pend_q   <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		if (act) begin
			rem_q <= rem_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (adv) begin
			tok_q <= nxt;
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

/* rtl/periodic_task_timer_table.sv */
// A request is registered in the head, then in each cell (visiting every cell once), then
// as the closing result in the output register; the chain holds while the output is stalled.
// Fire results come out as cells are passed; a new request waits for the closing result.
// Reset (arst_n low, asynchronous): every slot free, no pending slot, no request in flight.
// Remaining counts are not reset; a slot's count is loaded when the slot is added.
`timescale 1ns / 1ps
`default_nettype none

module periodic_task_timer_table (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // slot_id[4:0], period[20:5], keep[21], zero pad
	input  wire logic [1:0]  s_tuser,  // kind[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // result_id[4:0], zero pad
	output logic [2:0]       m_tuser,  // result_kind[2:0]
	output logic             m_tlast
);

	ptt_pkg::tok_t  head_q;
	ptt_pkg::tok_t  tok_link [ptt_pkg::SLOTS+1];
	ptt_pkg::fire_t fires [ptt_pkg::SLOTS];
	ptt_pkg::tok_t  end_tok;

	logic                      busy_q;
	logic                      out_valid_q;
	logic [ptt_pkg::RID_W-1:0] out_id_q;
	ptt_pkg::rkind_t           out_kind_q;
	logic                      out_last_q;

	logic                      adv, accept;
	logic                      e_valid, e_last;
	logic [ptt_pkg::ID_W-1:0]  e_id;
	ptt_pkg::rkind_t           e_kind;

	// chain moves only when the output register can take a result
	assign adv      = !out_valid_q || m_tready;
	assign s_tready = !busy_q;
	assign accept   = s_tvalid && s_tready;
	assign end_tok  = tok_link[ptt_pkg::SLOTS];

	assign tok_link[0] = head_q;

	for (genvar g = 0; g < ptt_pkg::SLOTS; g++) begin : g_cell
		ptt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.tok_in  (tok_link[g]),
			.tok_out (tok_link[g+1]),
			.fire    (fires[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
		end else if (accept) begin
			head_q.valid   <= 1'b1;
			head_q.kind    <= ptt_pkg::kind_t'(s_tuser[1:0]);
			head_q.slot_id <= s_tdata[4:0];
			head_q.period  <= s_tdata[20:5];
			head_q.keep    <= s_tdata[21];
			head_q.pos     <= '0;
			head_q.got     <= '0;
		end else if (adv) begin
			head_q.valid <= 1'b0;
		end
	end

	// only one token in flight, so at most one source is active
	always_comb begin
		e_valid = 1'b0;
		e_kind  = ptt_pkg::RK_FIRE;
		e_id    = '0;
		e_last  = 1'b0;
		for (int i = 0; i < ptt_pkg::SLOTS; i++) begin
			if (fires[i].valid) begin
				e_valid = 1'b1;
				e_id    = fires[i].id;
			end
		end
		if (end_tok.valid) begin
			e_valid = 1'b1;
			e_last  = 1'b1;
			e_id    = end_tok.got;
			case (end_tok.kind)
				ptt_pkg::K_TICK: begin
					e_kind = ptt_pkg::RK_TICKDONE;
					e_id   = '0;
				end
				ptt_pkg::K_ADD:    e_kind = ptt_pkg::RK_ADD;
				ptt_pkg::K_REMOVE: e_kind = ptt_pkg::RK_REMOVE;
				ptt_pkg::K_FINISH: e_kind = ptt_pkg::RK_FINISH;
				default:           e_kind = ptt_pkg::RK_FINISH;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (adv && end_tok.valid) begin
				busy_q <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= e_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && e_valid) begin
			out_id_q   <= ptt_pkg::RID_W'(e_id);
			out_kind_q <= e_kind;
			out_last_q <= e_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_id_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

/* rtl/ptt_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "periodic_task_timer_table_macros.svh"

module ptt_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [7:0]  m_tdata,
	input wire logic [2:0]  m_tuser,
	input wire logic        m_tlast
);

	`PTT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")

	// one request at a time: taking a request closes the input side
	`PTT_ASSERT_NEXT(a_one_req, s_tvalid && s_tready, !s_tready, "request accepted while busy")

	`PTT_ASSERT_SAME(a_tick_done, m_tvalid && m_tuser == ptt_pkg::RK_TICKDONE, m_tlast && m_tdata[4:0] == 5'd0, "tick done not last or nonzero id")

	`PTT_ASSERT_SAME(a_fire, m_tvalid && m_tuser == ptt_pkg::RK_FIRE, !m_tlast && m_tdata[4:0] != 5'd0, "fire result marked last or without id")

endmodule

bind periodic_task_timer_table ptt_checker u_ptt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire

/* tb/periodic_task_timer_table_checker.sv */
`timescale 1ns / 1ps

module periodic_task_timer_table_checker
	import ptt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [23:0]       s_tdata,
	input  logic [1:0]        s_tuser,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [7:0]        m_tdata,
	input  logic [2:0]        m_tuser,
	input  logic              m_tlast,
	output int                errors,
	output int                outstanding,
	output logic [SLOTS-1:0]  busy,
	output logic [SLOTS-1:0]  pending
);

	typedef struct packed {
		rkind_t           kind;
		logic [RID_W-1:0] id;
		logic             last;
	} timer_result_t;

	timer_result_t    due_results[$];
	timer_result_t    head;
	logic [PER_W-1:0] period_tbl[SLOTS];
	logic [PER_W-1:0] count_tbl[SLOTS];
	logic             pend_tbl[SLOTS];

	task automatic report(input string what);
		$display("[%0t] timer table mismatch: %s", $time, what);
		errors++;
	endtask

	// Applies one accepted request to the shadow table and queues its replies.
	function automatic void advance_timer_table(kind_t k, logic [SID_W-1:0] sid,
			logic [PER_W-1:0] per, logic keep);
		logic [RID_W-1:0] got;
		int s;
		got = '0;
		s = int'(sid) - 1;
		case (k)
			K_TICK: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (period_tbl[i] != '0 && !pend_tbl[i]) begin
						if (count_tbl[i] != '0) begin
							count_tbl[i] = count_tbl[i] - 1'b1;
						end else begin
							pend_tbl[i] = 1'b1;
							due_results.push_back('{kind: RK_FIRE, id: RID_W'(i + 1),
								last: 1'b0});
						end
					end
				end
				due_results.push_back('{kind: RK_TICKDONE, id: '0, last: 1'b1});
			end
			K_ADD: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (period_tbl[i] == '0) begin
						period_tbl[i] = per;
						count_tbl[i] = per;
						pend_tbl[i] = 1'b0;
						got = RID_W'(i + 1);
						break;
					end
				end
				due_results.push_back('{kind: RK_ADD, id: got, last: 1'b1});
			end
			K_REMOVE: begin
				if (sid >= 1 && sid <= SLOTS && period_tbl[s] != '0) begin
					period_tbl[s] = '0;
					pend_tbl[s] = 1'b0;
					got = RID_W'(sid);
				end
				due_results.push_back('{kind: RK_REMOVE, id: got, last: 1'b1});
			end
			default: begin
				if (sid >= 1 && sid <= SLOTS && period_tbl[s] != '0 && pend_tbl[s]) begin
					pend_tbl[s] = 1'b0;
					if (keep)
						count_tbl[s] = period_tbl[s];
					else
						period_tbl[s] = '0;
					got = RID_W'(sid);
				end
				due_results.push_back('{kind: RK_FINISH, id: got, last: 1'b1});
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_results.delete();
			for (int i = 0; i < SLOTS; i++) begin
				period_tbl[i] = '0;
				count_tbl[i] = '0;
				pend_tbl[i] = 1'b0;
			end
			errors = 0;
		end else begin
			// results leave before this edge's request can have produced any
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					report($sformatf("unexpected result kind %0d id %0d last %0b",
						m_tuser, m_tdata[4:0], m_tlast));
				end else begin
					head = due_results.pop_front();
					if (m_tuser !== head.kind)
						report($sformatf("result kind %0d, want %0d", m_tuser, head.kind));
					if (m_tdata[4:0] !== head.id)
						report($sformatf("result id %0d, want %0d (kind %0d)",
							m_tdata[4:0], head.id, head.kind));
					if (m_tdata[7:5] !== 3'b000)
						report($sformatf("result pad bits %b, want 000", m_tdata[7:5]));
					if (m_tlast !== head.last)
						report($sformatf("result last %0b, want %0b (kind %0d)",
							m_tlast, head.last, head.kind));
				end
			end
			if (s_tvalid && s_tready)
				advance_timer_table(kind_t'(s_tuser), s_tdata[4:0], s_tdata[20:5], s_tdata[21]);
		end
		outstanding <= due_results.size();
		for (int i = 0; i < SLOTS; i++) begin
			busy[i] <= (period_tbl[i] != '0);
			pending[i] <= pend_tbl[i];
		end
	end

endmodule

/* tb/tb_periodic_task_timer_table.sv */
`timescale 1ns / 1ps

module tb_periodic_task_timer_table;
	import ptt_pkg::*;

	localparam int REQUESTS    = 370;
	localparam int CYCLE_LIMIT = 1000000;

	logic             clk;
	logic             arst_n   = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [23:0]      s_tdata  = '0;
	logic [1:0]       s_tuser  = K_TICK;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [7:0]       m_tdata;
	logic [2:0]       m_tuser;
	logic             m_tlast;

	int               errors;
	int               outstanding;
	logic [SLOTS-1:0] busy;
	logic [SLOTS-1:0] pending;

	int               sent;
	int               cycles;
	int               stall_left;
	bit               ready_calm;
	bit               sender_calm;
	bit               paused_once;

	periodic_task_timer_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	periodic_task_timer_table_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.errors      (errors),
		.outstanding (outstanding),
		.busy        (busy),
		.pending     (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_periodic_task_timer_table: errors");
			$finish;
		end
	end

	// result-side backpressure: mostly short stalls, now and then a long one
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (!ready_calm && $urandom_range(0, 99) < 30) begin
			stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 30)
				: $urandom_range(0, 3);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
		if ($urandom_range(0, 299) == 0)
			ready_calm = !ready_calm;
	end

	function automatic int sender_gap();
		int r;
		r = $urandom_range(0, 99);
		if (sender_calm || r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	function automatic logic [SID_W-1:0] pick_id(logic [SLOTS-1:0] mask);
		int n;
		n = $countones(mask);
		if (n == 0)
			return '0;
		n = $urandom_range(0, n - 1);
		for (int i = 0; i < SLOTS; i++) begin
			if (mask[i]) begin
				if (n == 0)
					return SID_W'(i + 1);
				n--;
			end
		end
		return '0;
	endfunction

	function automatic logic [PER_W-1:0] pick_period();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		if (r < 75)
			return PER_W'($urandom_range(1, 4));
		return PER_W'($urandom_range(0, 65535));
	endfunction

	task automatic send(input kind_t k, input logic [SID_W-1:0] sid,
			input logic [PER_W-1:0] per, input logic keep);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= k;
		s_tdata  <= {2'b00, keep, per, sid};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
		gap = sender_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic random_request();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			send(K_TICK, SID_W'($urandom_range(0, 31)), PER_W'($urandom_range(0, 65535)),
				1'($urandom_range(0, 1)));
		end else if (r < 60) begin
			send(K_ADD, SID_W'($urandom_range(0, 31)), pick_period(), 1'($urandom_range(0, 1)));
		end else if (r < 75) begin
			send(K_REMOVE, ($urandom_range(0, 4) != 0) ? pick_id(busy)
				: SID_W'($urandom_range(0, 31)), PER_W'($urandom), 1'($urandom_range(0, 1)));
		end else begin
			send(K_FINISH, ($urandom_range(0, 6) != 0) ? pick_id(pending)
				: SID_W'($urandom_range(0, 31)), PER_W'($urandom), 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero period, extreme ids, bad removes, finish without fire,
		// fire / reload / re-fire, remove of a pending slot, finish that frees
		send(K_ADD, 5'd0, 16'd0, 1'b0);
		send(K_ADD, 5'd31, 16'hFFFF, 1'b1);
		send(K_ADD, 5'd0, 16'd1, 1'b0);
		send(K_ADD, 5'd0, 16'd0, 1'b0);
		send(K_REMOVE, 5'd0, 16'd0, 1'b0);
		send(K_REMOVE, 5'd31, 16'hFFFF, 1'b1);
		send(K_REMOVE, 5'd21, 16'd0, 1'b0);
		send(K_REMOVE, 5'd3, 16'd0, 1'b0);
		send(K_FINISH, 5'd2, 16'd0, 1'b1);
		send(K_TICK, 5'd31, 16'hFFFF, 1'b1);
		send(K_TICK, 5'd0, 16'd0, 1'b0);
		send(K_TICK, 5'd0, 16'd0, 1'b0);
		send(K_FINISH, 5'd2, 16'd0, 1'b1);
		send(K_FINISH, 5'd0, 16'd0, 1'b1);
		send(K_FINISH, 5'd31, 16'd0, 1'b0);
		send(K_TICK, 5'd0, 16'd0, 1'b0);
		send(K_TICK, 5'd0, 16'd0, 1'b0);
		send(K_REMOVE, 5'd2, 16'd0, 1'b0);
		send(K_ADD, 5'd0, 16'd2, 1'b0);
		send(K_TICK, 5'd0, 16'd0, 1'b0);
		send(K_TICK, 5'd0, 16'd0, 1'b0);
		send(K_TICK, 5'd0, 16'd0, 1'b0);
		send(K_FINISH, 5'd2, 16'd0, 1'b0);
		send(K_REMOVE, 5'd1, 16'd0, 1'b0);

		while (sent < REQUESTS) begin
			if ($urandom_range(0, 39) == 0)
				sender_calm = !sender_calm;
			if ($urandom_range(0, 59) == 0) begin
				// fill burst runs the table full
				repeat (SLOTS + 2)
					send(K_ADD, SID_W'($urandom_range(0, 31)), PER_W'($urandom_range(1, 4)),
						1'($urandom_range(0, 1)));
			end else begin
				random_request();
			end
			if (!paused_once && sent >= REQUESTS / 2) begin
				paused_once = 1'b1;
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (outstanding != 0)
					@(posedge clk);
			end
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("tb_periodic_task_timer_table: clean");
		else
			$display("tb_periodic_task_timer_table: errors");
		$finish;
	end

endmodule

/* periodic_task_timer_table.f */
+incdir+rtl
rtl/ptt_pkg.sv
rtl/ptt_cell.sv
rtl/periodic_task_timer_table.sv
rtl/ptt_checker.sv
tb/periodic_task_timer_table_checker.sv
tb/tb_periodic_task_timer_table.sv
